// ----- rtl/sstg_pkg.sv -----
// shared types, constants and the quarter-wave sine table for the tone generator
package sstg_pkg;

  localparam int unsigned PHASE_BITS = 32;
  localparam int unsigned ADDR_BITS  = 10;
  localparam int unsigned IDX_BITS   = ADDR_BITS + 1;
  localparam int unsigned QTR_LEN    = 1 << ADDR_BITS;
  localparam int unsigned STEP_BITS  = 32;
  localparam int unsigned GAIN_BITS  = 15;
  localparam int unsigned MAG_BITS   = 15;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned PROD_BITS  = MAG_BITS + GAIN_BITS + 1;

  localparam int unsigned CMD_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 4;

  localparam logic [MAG_BITS-1:0]  FULL_SCALE = MAG_BITS'(32767);
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_BITS - 1);
  localparam logic [IDX_BITS-1:0]  QTR_IDX    = IDX_BITS'(QTR_LEN);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef enum logic [1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_AMP_GAIN   = 2'd1,
    REG_WAVE_SEL   = 2'd2,
    REG_GEN_ENABLE = 2'd3
  } cfg_reg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                ok;
    logic                square;
    logic                neg;
    logic                zero;
    logic [IDX_BITS-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic                  ok;
    logic [VALUE_BITS-1:0] value;
  } out_item_t;

  typedef logic [MAG_BITS-1:0] sine_rom_t [0:QTR_LEN];

  // sin(k*pi/2^(ADDR_BITS+1)) in q1.15 via a 7-term integer taylor series in q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int k = 0; k <= int'(QTR_LEN); k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = MAG_BITS'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/sstg_front.sv -----
// front end: accepts items, owns the phase accumulator and classifies each frame
module sstg_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           restart_phase,
  input  logic                           cmd_full,
  input  logic [sstg_pkg::STEP_BITS-1:0] phase_step,
  input  logic                           wave_select,
  input  logic                           generator_enabled,
  output logic                           cmd_push,
  output sstg_pkg::cmd_t                 cmd
);

  logic [sstg_pkg::PHASE_BITS-1:0] phase;
  logic [sstg_pkg::PHASE_BITS-1:0] phase_cur;
  logic [sstg_pkg::PHASE_BITS-1:0] phase_next;
  logic [1:0]                      quad;
  logic [sstg_pkg::IDX_BITS-1:0]   fine;

  assign cmd_push  = push & ~cmd_full;
  // restart clears the phase before this frame is taken
  assign phase_cur = restart_phase ? '0 : phase;
  assign quad      = phase_cur[sstg_pkg::PHASE_BITS-1 -: 2];
  assign fine      = {1'b0, phase_cur[sstg_pkg::PHASE_BITS-3 -: sstg_pkg::ADDR_BITS]};

  always_comb begin
    phase_next = phase;
    if (cmd_push) begin
      phase_next = generator_enabled
                   ? phase_cur + sstg_pkg::PHASE_BITS'(phase_step)
                   : phase_cur;
    end
  end

  always_comb begin
    cmd.ok     = generator_enabled;
    cmd.square = wave_select;
    cmd.neg    = phase_cur[sstg_pkg::PHASE_BITS-1];
    // exact zero or exact half phase
    cmd.zero   = (phase_cur[sstg_pkg::PHASE_BITS-2:0] == '0);
    cmd.idx    = quad[0] ? (sstg_pkg::QTR_IDX - fine) : fine;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

// ----- rtl/sstg_cmd_queue.sv -----
// short queue of classified items between front and back
module sstg_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sstg_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output sstg_pkg::cmd_t dout,
  output logic           empty
);

  localparam int unsigned PTR_BITS = $clog2(sstg_pkg::CMD_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(sstg_pkg::CMD_DEPTH + 1);

  sstg_pkg::cmd_t      mem [sstg_pkg::CMD_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full  = (count == CNT_BITS'(sstg_pkg::CMD_DEPTH));
  assign empty = (count == '0);
  assign do_wr = push & ~full;
  assign do_rd = pop & ~empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(do_wr) - CNT_BITS'(do_rd);
    end
  end

endmodule

// ----- rtl/sstg_back.sv -----
// back end: table lookup, amplitude scaling and the result queue
module sstg_back (
  input  logic                                clk,
  input  logic                                rst,
  input  sstg_pkg::cmd_t                      cmd,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  input  logic [sstg_pkg::GAIN_BITS-1:0]      amplitude_gain,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [sstg_pkg::VALUE_BITS-1:0] sample_value,
  output logic                                sample_ok
);

  localparam int unsigned PTR_BITS = $clog2(sstg_pkg::OUT_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(sstg_pkg::OUT_DEPTH + 3);

  // stage 1: rom read
  logic                          s1_valid;
  sstg_pkg::cmd_t                s1_cmd;
  logic [sstg_pkg::MAG_BITS-1:0] rom_q;
  logic [sstg_pkg::MAG_BITS-1:0] s1_mag;

  // stage 2: scaled product
  logic                           s2_valid;
  logic                           s2_ok;
  logic                           s2_neg;
  logic [sstg_pkg::PROD_BITS-1:0] s2_prod;

  logic [sstg_pkg::VALUE_BITS-1:0] scaled;
  logic [sstg_pkg::VALUE_BITS-1:0] sat;
  sstg_pkg::out_item_t             wr_item;

  sstg_pkg::out_item_t mem [sstg_pkg::OUT_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] committed;
  logic                do_rd;

  // room for everything already in flight plus this item
  assign committed = count + CNT_BITS'(s1_valid) + CNT_BITS'(s2_valid);
  assign cmd_pop   = ~cmd_empty & (committed < CNT_BITS'(sstg_pkg::OUT_DEPTH));

  always_comb begin
    if (!s1_cmd.ok) begin
      s1_mag = '0;
    end else if (s1_cmd.square) begin
      s1_mag = s1_cmd.zero ? '0 : sstg_pkg::FULL_SCALE;
    end else begin
      s1_mag = rom_q;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd  <= cmd;
    rom_q   <= sstg_pkg::SINE_ROM[cmd.idx];
    s2_ok   <= s1_cmd.ok;
    s2_neg  <= s1_cmd.neg;
    s2_prod <= sstg_pkg::PROD_BITS'(s1_mag) * sstg_pkg::PROD_BITS'(amplitude_gain)
               + sstg_pkg::ROUND_HALF;
  end

  always_comb begin
    scaled = s2_prod[sstg_pkg::GAIN_BITS +: sstg_pkg::VALUE_BITS];
    sat    = scaled[sstg_pkg::VALUE_BITS-1] ? sstg_pkg::VALUE_BITS'(sstg_pkg::FULL_SCALE)
                                            : scaled;
    wr_item.ok    = s2_ok;
    wr_item.value = s2_neg ? (~sat + sstg_pkg::VALUE_BITS'(1)) : sat;
  end

  assign empty        = (count == '0);
  assign do_rd        = pop & ~empty;
  assign sample_value = mem[rd_ptr].value;
  assign sample_ok    = mem[rd_ptr].ok;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      s1_valid <= cmd_pop;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(s2_valid) - CNT_BITS'(do_rd);
    end
  end

endmodule

// ----- rtl/sine_square_tone_generator.sv -----
// tone generator top level: config registers, front, item queue and back
// each item passes the item queue, the rom read and product registers, then the result queue
// throughput: one item per cycle while the item queue is not full
// the back pipeline (rom read, multiply) holds two items, results queue 4 deep
// rst (synchronous): config registers, phase and all queues clear; no clearing pass
module sine_square_tone_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   restart_phase,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [sstg_pkg::VALUE_BITS-1:0] sample_value,
  output logic                                   sample_ok,
  input  logic                                   cfg_write,
  input  logic [1:0]                             cfg_index,
  input  logic [sstg_pkg::CFG_BITS-1:0]          cfg_data
);

  logic [sstg_pkg::STEP_BITS-1:0] phase_step;
  logic [sstg_pkg::GAIN_BITS-1:0] amplitude_gain;
  logic                           wave_select;
  logic                           generator_enabled;

  logic           cmd_push;
  logic           cmd_pop;
  logic           cmd_empty;
  sstg_pkg::cmd_t cmd_in;
  sstg_pkg::cmd_t cmd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step        <= '0;
      amplitude_gain    <= '0;
      wave_select       <= 1'b0;
      generator_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (sstg_pkg::cfg_reg_t'(cfg_index))
        sstg_pkg::REG_PHASE_STEP: phase_step <= cfg_data[sstg_pkg::STEP_BITS-1:0];
        sstg_pkg::REG_AMP_GAIN:   amplitude_gain <= cfg_data[sstg_pkg::GAIN_BITS-1:0];
        sstg_pkg::REG_WAVE_SEL:   wave_select <= cfg_data[0];
        sstg_pkg::REG_GEN_ENABLE: generator_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sstg_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .restart_phase     (restart_phase),
    .cmd_full          (full),
    .phase_step        (phase_step),
    .wave_select       (wave_select),
    .generator_enabled (generator_enabled),
    .cmd_push          (cmd_push),
    .cmd               (cmd_in)
  );

  sstg_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  sstg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_out),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .amplitude_gain (amplitude_gain),
    .pop            (pop),
    .empty          (empty),
    .sample_value   (sample_value),
    .sample_ok      (sample_ok)
  );

  // queues come out of reset drained
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not drained after reset");

  // a rejected frame carries a zero sample
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !sample_ok) |-> (sample_value == '0))
    else $error("rejected frame with nonzero sample");

  // scaling is symmetric, so the most negative code never appears
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (sample_value != {1'b1, {(sstg_pkg::VALUE_BITS-1){1'b0}}}))
    else $error("sample outside symmetric range");

endmodule
